// ----- rtl/core/csre_pkg.sv -----
// Package for the cartesian shell rotation entry block: types, constants, index decoding.
`timescale 1ns / 1ps

package csre_pkg;

  localparam int MAX_ORDER_DEF = 4;
  localparam int FRAC_BITS     = 14;
  localparam int ONE_Q14       = 16384;
  localparam int ROUND_HALF    = 8192;

  typedef struct packed {
    logic signed [15:0] op_xx;
    logic signed [15:0] op_xy;
    logic signed [15:0] op_xz;
    logic signed [15:0] op_yx;
    logic signed [15:0] op_yy;
    logic signed [15:0] op_yz;
    logic signed [15:0] op_zx;
    logic signed [15:0] op_zy;
    logic signed [15:0] op_zz;
    logic [2:0]         shell_order;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
  } op_t;

  typedef struct packed {
    logic signed [31:0] entry_value;
    logic               bad_index;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // x, y and z powers of one cartesian function
  typedef struct packed {
    logic [2:0] px;
    logic [2:0] py;
    logic [2:0] pz;
  } powers_t;

  // number of cartesian functions of order l: (l+1)(l+2)/2
  function automatic logic [5:0] shell_size(logic [2:0] l);
    logic [6:0] prod;
    prod = ({4'd0, l} + 7'd1) * ({4'd0, l} + 7'd2);
    return prod[6:1];
  endfunction

  // x-power outer, z-power inner numbering
  function automatic powers_t decode_powers(logic [2:0] l, logic [3:0] idx);
    powers_t    pw;
    logic [5:0] n;
    logic       found;
    pw    = '0;
    n     = '0;
    found = 1'b0;
    for (int a = 0; a < 8; a++) begin
      for (int c = 0; c < 8; c++) begin
        if (a + c <= int'(l)) begin
          if (!found && n == {2'b00, idx}) begin
            pw.px = 3'(a);
            pw.py = 3'(int'(l) - a - c);
            pw.pz = 3'(c);
            found = 1'b1;
          end
          n = n + 6'd1;
        end
      end
    end
    return pw;
  endfunction

endpackage

// ----- rtl/core/csre_mul_round.sv -----
// Shared multiply and round unit: q = floor((p * m + 2^13) / 2^14).
`timescale 1ns / 1ps

module csre_mul_round
  import csre_pkg::*;
#(
  parameter int PW = 16 + MAX_ORDER_DEF
) (
  input  logic signed [PW-1:0] p,
  input  logic signed [15:0]   m,
  output logic signed [PW-1:0] q
);

  logic signed [PW+15:0] prod;
  logic signed [PW+15:0] rnd;

  assign prod = p * m;
  assign rnd  = prod + (PW+16)'(ROUND_HALF);
  // arithmetic floor: drop the fraction bits of the two's complement value
  assign q    = rnd[PW+FRAC_BITS-1:FRAC_BITS];

endmodule

// ----- rtl/core/cartesian_shell_rotation_entry.sv -----
// Top level: one entry of the cartesian shell transform, computed on one shared multiplier.
//
//  channel | direction | handshake          | payload
//  op      | in        | op_valid/op_stall  | op_data  (op_t: matrix, order, row, column)
//  res     | out       | res_valid/res_stall| res_data (res_t: entry_value, bad_index)
//
// Bad index or l = 0: straight from accept to the result. Otherwise all 3^l axis tuples
// are scanned, one per cycle while no product is in work; each match gets an l-factor
// product, one multiply per cycle, which is then added to the sum.
// rst is synchronous and clears the sequencer and the result valid.
// op_stall is high while an item is in work; a finished result waits in the
// output register and the next item may start meanwhile.
`timescale 1ns / 1ps

module cartesian_shell_rotation_entry
  import csre_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_stall,
  input  op_t  op_data,
  output logic res_valid,
  input  logic res_stall,
  output res_t res_data
);

  localparam int PW = 16 + MAX_ORDER;
  localparam int SW = (PW + 12 > 33) ? PW + 12 : 33;
  localparam int KW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-31){1'b1}}, {31{1'b0}}};

  state_t state, state_next;

  logic signed [15:0] mat [3][3];
  logic [2:0]         ord;
  powers_t            rpw, cpw;
  logic [1:0]         tup [MAX_ORDER];
  logic [1:0]         tup_inc [MAX_ORDER];
  logic [KW-1:0]      k;
  logic signed [PW-1:0] p, q;
  logic signed [SW-1:0] sum;
  logic               bad;

  logic       accept, load, bad_in, l0_in;
  logic       match, last, k_last;
  logic [2:0] cnt_x, cnt_y, cnt_z;
  logic [3:0] k_ext, seq_lim_x, seq_lim_y;
  axis_t      seq_axis;
  logic [1:0] tup_k;
  logic signed [15:0] elem;
  logic signed [31:0] sat_sum;
  logic [5:0] size_in;

  // ---------------- input decode ----------------
  assign size_in = shell_size(op_data.shell_order);
  assign bad_in  = ({1'b0, op_data.shell_order} > 4'(MAX_ORDER))
                || ({2'b00, op_data.row_index} >= size_in)
                || ({2'b00, op_data.col_index} >= size_in);
  assign l0_in   = (op_data.shell_order == 3'd0);

  assign op_stall = (state != ST_IDLE);
  assign accept   = op_valid && !op_stall;

  // ---------------- tuple scan ----------------
  always_comb begin
    cnt_x = '0;
    cnt_y = '0;
    cnt_z = '0;
    last  = 1'b1;
    for (int i = 0; i < MAX_ORDER; i++) begin
      if (3'(i) < ord) begin
        case (tup[i])
          AXIS_X:  cnt_x = cnt_x + 3'd1;
          AXIS_Y:  cnt_y = cnt_y + 3'd1;
          default: cnt_z = cnt_z + 3'd1;
        endcase
        if (tup[i] != AXIS_Z) last = 1'b0;
      end
    end
  end

  assign match = (cnt_x == cpw.px) && (cnt_y == cpw.py) && (cnt_z == cpw.pz);

  // base-3 increment of the axis tuple, digit 0 lowest
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < MAX_ORDER; i++) begin
      tup_inc[i] = tup[i];
      if (carry) begin
        if (tup[i] == AXIS_Z) begin
          tup_inc[i] = AXIS_X;
        end else begin
          tup_inc[i] = tup[i] + 2'd1;
          carry      = 1'b0;
        end
      end
    end
  end

  // ---------------- element select for the multiplier ----------------
  assign k_ext     = 4'(k);
  assign seq_lim_x = {1'b0, rpw.px};
  assign seq_lim_y = {1'b0, rpw.px} + {1'b0, rpw.py};

  always_comb begin
    if (k_ext < seq_lim_x)      seq_axis = AXIS_X;
    else if (k_ext < seq_lim_y) seq_axis = AXIS_Y;
    else                        seq_axis = AXIS_Z;
  end

  assign tup_k  = tup[k];
  assign elem   = mat[seq_axis][tup_k];
  assign k_last = (3'(k) == ord - 3'd1);

  csre_mul_round #(.PW(PW)) u_mul (
    .p (p),
    .m (elem),
    .q (q)
  );

  // ---------------- sequencer ----------------
  assign load = (state == ST_FIN) && !(res_valid && res_stall);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = (bad_in || l0_in) ? ST_FIN : ST_SCAN;
      ST_SCAN: begin
        if (match)     state_next = ST_MUL;
        else if (last) state_next = ST_FIN;
      end
      ST_MUL:  if (k_last) state_next = ST_ACC;
      ST_ACC:  state_next = last ? ST_FIN : ST_SCAN;
      ST_FIN:  if (load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      mat[0][0] <= op_data.op_xx;
      mat[0][1] <= op_data.op_xy;
      mat[0][2] <= op_data.op_xz;
      mat[1][0] <= op_data.op_yx;
      mat[1][1] <= op_data.op_yy;
      mat[1][2] <= op_data.op_yz;
      mat[2][0] <= op_data.op_zx;
      mat[2][1] <= op_data.op_zy;
      mat[2][2] <= op_data.op_zz;
      ord       <= op_data.shell_order;
      rpw       <= decode_powers(op_data.shell_order, op_data.row_index);
      cpw       <= decode_powers(op_data.shell_order, op_data.col_index);
      bad       <= bad_in;
      for (int i = 0; i < MAX_ORDER; i++) tup[i] <= AXIS_X;
      if (!bad_in && l0_in) sum <= SW'(ONE_Q14);
      else                  sum <= '0;
    end
    case (state)
      ST_SCAN: begin
        if (match) begin
          k <= '0;
          p <= PW'(ONE_Q14);
        end else if (!last) begin
          tup <= tup_inc;
        end
      end
      ST_MUL: begin
        p <= q;
        k <= k + KW'(1);
      end
      ST_ACC: begin
        sum <= sum + SW'(p);
        if (!last) tup <= tup_inc;
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_comb begin
    if (sum > SAT_HI)      sat_sum = 32'sh7fffffff;
    else if (sum < SAT_LO) sat_sum = 32'sh80000000;
    else                   sat_sum = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data.entry_value <= sat_sum;
      res_data.bad_index   <= bad;
    end
  end

endmodule

// ----- test/tb_cartesian_shell_rotation_entry.sv -----
// Testbench for the cartesian shell rotation entry block: predicts each entry and checks results.
`timescale 1ns / 1ps

module tb_cartesian_shell_rotation_entry;
  import csre_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 200;
  localparam int ORDER_LIMIT  = MAX_ORDER_DEF;
  localparam int MAX_PRINTS   = 40;
  localparam int RANDOM_ITEMS = 400;

  typedef enum int {
    MAT_RANDOM,
    MAT_SMALL,
    MAT_EXTREME,
    MAT_IDENTITY,
    MAT_ALL_MAX,
    MAT_ALL_MIN
  } mat_style_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic op_valid  = 1'b0;
  logic op_stall;
  op_t  op_data   = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;

  res_t entry_q[$];
  res_t res_want;
  int   err_cnt   = 0;
  int   cycle_cnt = 0;

  logic rx_hold_go   = 1'b0;
  logic rx_hold_done = 1'b0;
  int   rx_hold_cnt  = 0;
  int   rx_gap_left  = 0;
  logic rx_quiet     = 1'b0;

  cartesian_shell_rotation_entry DUT (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_stall (op_stall),
    .op_data  (op_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic powers_t powers_of(int l, int idx);
    powers_t pw;
    int      num;
    pw  = '0;
    num = 0;
    for (int a = 0; a <= l; a++) begin
      for (int c = 0; c <= l - a; c++) begin
        if (num == idx) begin
          pw.px = 3'(a);
          pw.py = 3'(l - a - c);
          pw.pz = 3'(c);
        end
        num++;
      end
    end
    return pw;
  endfunction

  function automatic res_t predict_entry(op_t op);
    res_t               r;
    logic signed [15:0] mat [3][3];
    powers_t            rp;
    powers_t            cp;
    axis_t              seq [ORDER_LIMIT];
    axis_t              dig [ORDER_LIMIT];
    int                 cnt [3];
    int                 l;
    int                 nfun;
    int                 total;
    int                 rem;
    int                 k;
    longint             prod;
    longint             acc;
    l    = int'(op.shell_order);
    nfun = (l + 1) * (l + 2) / 2;
    r    = '0;
    if (l > ORDER_LIMIT || int'(op.row_index) >= nfun || int'(op.col_index) >= nfun) begin
      r.bad_index = 1'b1;
      return r;
    end
    if (l == 0) begin
      r.entry_value = ONE_Q14;
      return r;
    end
    mat[0][0] = $signed(op.op_xx);
    mat[0][1] = $signed(op.op_xy);
    mat[0][2] = $signed(op.op_xz);
    mat[1][0] = $signed(op.op_yx);
    mat[1][1] = $signed(op.op_yy);
    mat[1][2] = $signed(op.op_yz);
    mat[2][0] = $signed(op.op_zx);
    mat[2][1] = $signed(op.op_zy);
    mat[2][2] = $signed(op.op_zz);
    rp = powers_of(l, int'(op.row_index));
    cp = powers_of(l, int'(op.col_index));
    // row powers unrolled into an axis sequence: x's, then y's, then z's
    k = 0;
    for (int j = 0; j < int'(rp.px); j++) begin seq[k] = AXIS_X; k++; end
    for (int j = 0; j < int'(rp.py); j++) begin seq[k] = AXIS_Y; k++; end
    for (int j = 0; j < int'(rp.pz); j++) begin seq[k] = AXIS_Z; k++; end
    total = 1;
    for (int j = 0; j < l; j++) total = total * 3;
    acc = 0;
    for (int t = 0; t < total; t++) begin
      rem = t;
      cnt[0] = 0;
      cnt[1] = 0;
      cnt[2] = 0;
      for (int j = 0; j < l; j++) begin
        dig[j] = axis_t'(rem % 3);
        rem    = rem / 3;
        cnt[int'(dig[j])]++;
      end
      if (cnt[0] == int'(cp.px) && cnt[1] == int'(cp.py) && cnt[2] == int'(cp.pz)) begin
        prod = ONE_Q14;
        // round half up to Q.14 after every multiply (>>> floors)
        for (int j = 0; j < l; j++)
          prod = (prod * longint'(mat[int'(seq[j])][int'(dig[j])]) + ROUND_HALF) >>> FRAC_BITS;
        acc = acc + prod;
      end
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    r.entry_value = 32'(acc);
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    if (err_cnt < MAX_PRINTS) $display("[cycle %0d] mismatch: %s", cycle_cnt, what);
    err_cnt = err_cnt + 1;
  endtask

  // results are checked before the new transaction is queued, so order within the edge is fixed
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (entry_q.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0b with nothing pending",
                                    $signed(res_data.entry_value), res_data.bad_index));
        end else begin
          res_want = entry_q.pop_front();
          if (res_data.entry_value !== res_want.entry_value)
            report_mismatch($sformatf("entry_value got %0d want %0d",
                                      $signed(res_data.entry_value),
                                      $signed(res_want.entry_value)));
          if (res_data.bad_index !== res_want.bad_index)
            report_mismatch($sformatf("bad_index got %0b want %0b",
                                      res_data.bad_index, res_want.bad_index));
        end
      end
      if (op_valid && !op_stall) entry_q.push_back(predict_entry(op_data));
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [15:0] pick_element(mat_style_t s, int pos);
    int v;
    case (s)
      MAT_RANDOM:   return 16'($urandom_range(0, 65535));
      MAT_SMALL: begin
        v = int'($urandom_range(0, 32768)) - 16384;
        return 16'(v);
      end
      MAT_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          3:       return 16'h4000;
          default: return 16'hC000;
        endcase
      end
      MAT_IDENTITY: return (pos % 4 == 0) ? 16'h4000 : 16'h0000;
      MAT_ALL_MAX:  return 16'h7FFF;
      default:      return 16'h8000;
    endcase
  endfunction

  function automatic op_t build_op(int l, int row, int col, mat_style_t s);
    op_t         op;
    logic [15:0] e [9];
    for (int i = 0; i < 9; i++) e[i] = pick_element(s, i);
    op.op_xx       = e[0];
    op.op_xy       = e[1];
    op.op_xz       = e[2];
    op.op_yx       = e[3];
    op.op_yy       = e[4];
    op.op_yz       = e[5];
    op.op_zx       = e[6];
    op.op_zy       = e[7];
    op.op_zz       = e[8];
    op.shell_order = 3'(l);
    op.row_index   = 4'(row);
    op.col_index   = 4'(col);
    return op;
  endfunction

  function automatic op_t random_item();
    int         r;
    int         l;
    int         nfun;
    int         row;
    int         col;
    mat_style_t s;
    r = $urandom_range(0, 99);
    if (r < 5)       l = 0;
    else if (r < 10) l = $urandom_range(5, 7);
    else             l = $urandom_range(1, 4);
    nfun = (l + 1) * (l + 2) / 2;
    if (nfun > 16) nfun = 16;
    if ($urandom_range(0, 9) == 0) begin
      row = $urandom_range(0, 15);
      col = $urandom_range(0, 15);
    end else begin
      row = $urandom_range(0, nfun - 1);
      col = $urandom_range(0, nfun - 1);
    end
    r = $urandom_range(0, 9);
    s = (r < 4) ? MAT_RANDOM : (r < 8) ? MAT_SMALL : MAT_EXTREME;
    return build_op(l, row, col, s);
  endfunction

  // called at a falling edge; returns at a falling edge after the gap
  task automatic send_op(input op_t op, input int gap);
    op_data  <= op;
    op_valid <= 1'b1;
    do @(posedge clk); while (op_stall);
    @(negedge clk);
    if (gap > 0) begin
      op_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic settle_all();
    op_valid <= 1'b0;
    while (entry_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_corners();
    send_op(build_op(0, 0, 0, MAT_RANDOM), 0);
    send_op(build_op(0, 1, 0, MAT_RANDOM), 0);
    send_op(build_op(0, 0, 15, MAT_RANDOM), 0);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_op(build_op(1, r, c, MAT_RANDOM), 0);
    send_op(build_op(2, 0, 5, MAT_ALL_MAX), 1);
    send_op(build_op(3, 9, 9, MAT_EXTREME), 0);
    send_op(build_op(3, 10, 0, MAT_RANDOM), 0);
    send_op(build_op(4, 14, 14, MAT_ALL_MIN), 0);
    send_op(build_op(4, 4, 4, MAT_ALL_MIN), 2);
    send_op(build_op(4, 7, 8, MAT_RANDOM), 0);
    send_op(build_op(4, 15, 0, MAT_RANDOM), 0);
    send_op(build_op(4, 0, 15, MAT_RANDOM), 0);
    // orders above the supported maximum
    send_op(build_op(5, 0, 0, MAT_RANDOM), 0);
    send_op(build_op(6, 3, 2, MAT_RANDOM), 0);
    send_op(build_op(7, 15, 15, MAT_ALL_MAX), 0);
    send_op(build_op(4, 3, 12, MAT_IDENTITY), 0);
    settle_all();
  endtask

  task automatic test_output_backpressure();
    // receiver holds off on its own count while the sender keeps offering
    rx_hold_go <= 1'b1;
    for (int i = 0; i < 12; i++)
      send_op(build_op($urandom_range(1, 2), $urandom_range(0, 2), $urandom_range(0, 2),
                       MAT_SMALL), 0);
    op_valid <= 1'b0;
    while (!rx_hold_done) @(negedge clk);
    settle_all();
  endtask

  task automatic test_pause_until_empty();
    for (int i = 0; i < 8; i++) send_op(random_item(), gap_length());
    settle_all();
    for (int i = 0; i < 8; i++) send_op(random_item(), 0);
    settle_all();
  endtask

  task automatic test_random_items(input int count);
    bit quiet;
    int gap;
    quiet = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      gap = quiet ? 0 : gap_length();
      send_op(random_item(), gap);
    end
    settle_all();
  endtask

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (rx_hold_go && !rx_hold_done) begin
      res_stall   <= 1'b1;
      rx_hold_cnt <= rx_hold_cnt + 1;
      if (rx_hold_cnt == HOLD_CYCLES - 1) rx_hold_done <= 1'b1;
    end else if (rx_gap_left > 0) begin
      res_stall   <= 1'b1;
      rx_gap_left <= rx_gap_left - 1;
    end else begin
      res_stall <= 1'b0;
      if ($urandom_range(0, 299) == 0) rx_quiet <= !rx_quiet;
      if (!rx_quiet && $urandom_range(0, 3) == 0) rx_gap_left <= gap_length();
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_corners();
    test_output_backpressure();
    test_pause_until_empty();
    test_random_items(RANDOM_ITEMS);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
